FILE: rtl/core/bit_serial_crc_lfsr_macros.svh
// Assertion macros shared by the bit-serial CRC block.
`ifndef BIT_SERIAL_CRC_LFSR_MACROS_SVH
`define BIT_SERIAL_CRC_LFSR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define BSC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bit_serial_crc_lfsr: same-cycle check failed");
// Next-cycle implication.
`define BSC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bit_serial_crc_lfsr: next-cycle check failed");
`else
`define BSC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BSC_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/bscrc_pkg.sv
// Package: widths, register indexes, control struct and LFSR step functions.
package bscrc_pkg;

    localparam int MAX_DEGREE = 32;
    localparam int IDX_W      = $clog2(MAX_DEGREE);
    localparam int DEG_W      = 6;
    localparam int TAP_W      = 32;
    localparam int CRC_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_FILL = 2'd2;

    localparam logic [TAP_W-1:0] TAP_MASK_RST = 32'h0000_1021;
    localparam logic [DEG_W-1:0] DEGREE_RST   = 6'd16;

    typedef logic [MAX_DEGREE-1:0] lfsr_t;

    // Sequencer to shift register
    typedef struct packed {
        logic step;      // shift one bit this cycle
        logic bit_in;    // bit entering at bit 0
        logic restart;   // start of message: use fill as the base
    } lfsr_ctl_t;

    // Degree clamped to 1..MAX_DEGREE
    function automatic logic [DEG_W-1:0] eff_degree(input logic [DEG_W-1:0] deg);
        logic [DEG_W-1:0] d;
        d = deg;
        if (deg == '0) begin
            d = DEG_W'(1);
        end else if (deg > DEG_W'(MAX_DEGREE)) begin
            d = DEG_W'(MAX_DEGREE);
        end
        return d;
    endfunction

    function automatic lfsr_t width_mask(input logic [DEG_W-1:0] d);
        lfsr_t m;
        for (int i = 0; i < MAX_DEGREE; i++) begin
            m[i] = (DEG_W'(i) < d);
        end
        return m;
    endfunction

    function automatic lfsr_t fill_value(input logic fill, input logic [DEG_W-1:0] d);
        return fill ? width_mask(d) : '0;
    endfunction

    // One Galois shift: bit in at 0, taps folded in when the top bit leaves as 1
    function automatic lfsr_t lfsr_step(input lfsr_t st, input logic bit_in,
                                        input logic [DEG_W-1:0] d,
                                        input logic [TAP_W-1:0] taps);
        lfsr_t m;
        lfsr_t nxt;
        lfsr_t tap_ext;
        logic  top;
        m       = width_mask(d);
        top     = st[IDX_W'(d - DEG_W'(1))];
        tap_ext = MAX_DEGREE'(taps) | lfsr_t'(1);
        nxt     = {st[MAX_DEGREE-2:0], bit_in} & m;
        if (top) begin
            nxt = nxt ^ (tap_ext & m);
        end
        return nxt;
    endfunction

endpackage

FILE: rtl/core/bscrc_lfsr.sv
// Galois shift register: one bit per cycle while ctl.step is high, masked to the active degree.
`include "bit_serial_crc_lfsr_macros.svh"
module bscrc_lfsr import bscrc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  lfsr_ctl_t        ctl,
    input  logic [DEG_W-1:0] deg,
    input  logic [TAP_W-1:0] taps,
    input  logic             init_fill,
    output lfsr_t            lfsr_state
);

    lfsr_t shift_reg_reg;
    lfsr_t shift_reg_next;
    lfsr_t base;
    lfsr_t mask;

    assign mask = width_mask(deg);

    always_comb begin
        base           = ctl.restart ? fill_value(init_fill, deg) : (shift_reg_reg & mask);
        shift_reg_next = shift_reg_reg;
        if (ctl.step) begin
            shift_reg_next = lfsr_step(base, ctl.bit_in, deg, taps);
        end
    end

    // payload only; the sequencer forces a reload on the first bit
    always_ff @(posedge aclk) begin
        shift_reg_reg <= shift_reg_next;
    end

    assign lfsr_state = shift_reg_reg;

    `BSC_ASSERT_NXT(a_above_degree_clear, aclk, aresetn, ctl.step, (shift_reg_reg & ~$past(mask)) == '0)

endmodule

FILE: rtl/core/bscrc_ctrl.sv
// Sequencer: input handshake, zero-flush counter and result hand-off.
`include "bit_serial_crc_lfsr_macros.svh"
module bscrc_ctrl import bscrc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_data_bit,
    input  logic             s_last,
    input  logic [DEG_W-1:0] deg,
    input  logic             out_free,
    output lfsr_ctl_t        ctl,
    output logic             out_load
);

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [DEG_W-1:0] flush_cnt_reg, flush_cnt_next;
    logic             in_msg_reg, in_msg_next;
    logic             accept;

    assign s_ready = (state_reg == ST_RUN);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        flush_cnt_next = flush_cnt_reg;
        in_msg_next    = in_msg_reg;
        ctl            = '0;
        out_load       = 1'b0;
        case (state_reg)
            ST_RUN: begin
                if (accept) begin
                    ctl.step    = 1'b1;
                    ctl.bit_in  = s_data_bit;
                    ctl.restart = !in_msg_reg;
                    in_msg_next = 1'b1;
                    if (s_last) begin
                        state_next     = ST_FLUSH;
                        flush_cnt_next = '0;
                    end
                end
            end
            ST_FLUSH: begin
                ctl.step       = 1'b1;
                flush_cnt_next = flush_cnt_reg + DEG_W'(1);
                if (flush_cnt_reg == deg - DEG_W'(1)) begin
                    state_next     = ST_DONE;
                    flush_cnt_next = '0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    in_msg_next = 1'b0;
                    state_next  = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            flush_cnt_reg <= '0;
            in_msg_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            flush_cnt_reg <= flush_cnt_next;
            in_msg_reg    <= in_msg_next;
        end
    end

    `BSC_ASSERT_IMP(a_flush_in_range, aclk, aresetn, state_reg == ST_FLUSH, flush_cnt_reg < deg)
    `BSC_ASSERT_NXT(a_last_starts_flush, aclk, aresetn, accept && s_last, state_reg == ST_FLUSH)
    `BSC_ASSERT_IMP(a_done_in_msg, aclk, aresetn, state_reg == ST_DONE, in_msg_reg)

endmodule

FILE: rtl/core/bit_serial_crc_lfsr.sv
// Top level: bit-serial augmented-message CRC with programmable polynomial.
//
// Bit-serial CRC generator. Message bits come in one per cycle when ready, most
// significant first, on the s_ channel; s_last marks the final bit. Each bit
// moves through a Galois shift register of the programmed degree (1..32, a
// degree of 0 behaves as 1 and anything above 32 as 32); when the bit leaving
// the top is 1 the tap_mask bits below degree, plus x^0, are inverted. After
// the last bit the block shifts in degree zero bits, one per cycle, then hands
// the remainder (right-aligned, upper bits zero) to the m_ output register.
// After the last bit is taken s_ready stays low through the flush and the
// hand-off (states ST_FLUSH and ST_DONE). If the previous result is still
// unread the hand-off waits for it. The first bit of each message reloads
// every active register bit with init_fill. Configuration registers (index 0
// tap_mask, 1 degree, 2 init_fill) are written through cfg_*, which is always
// ready; writes are only meant between words, never during a flush.

`include "bit_serial_crc_lfsr_macros.svh"
module bit_serial_crc_lfsr import bscrc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // message bits
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_data_bit,
    input  logic                  s_last,
    // remainder
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CRC_W-1:0]      m_crc_value,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ---- configuration registers ----
    logic [TAP_W-1:0] tap_mask_reg;
    logic [DEG_W-1:0] degree_reg;
    logic             init_fill_reg;
    logic             cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_mask_reg  <= TAP_MASK_RST;
            degree_reg    <= DEGREE_RST;
            init_fill_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_TAP_MASK:  tap_mask_reg  <= cfg_data[TAP_W-1:0];
                REG_DEGREE:    degree_reg    <= cfg_data[DEG_W-1:0];
                REG_INIT_FILL: init_fill_reg <= cfg_data[0];
                default: begin
                    // unmapped index: write ignored
                end
            endcase
        end
    end

    // clamped degree used everywhere in the datapath
    logic [DEG_W-1:0] deg_eff;
    assign deg_eff = eff_degree(degree_reg);

    // ---- sequencer and shift register ----
    lfsr_ctl_t ctl;
    lfsr_t     lfsr_state;
    logic      out_load;
    logic      out_free;

    bscrc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data_bit (s_data_bit),
        .s_last     (s_last),
        .deg        (deg_eff),
        .out_free   (out_free),
        .ctl        (ctl),
        .out_load   (out_load)
    );

    bscrc_lfsr u_lfsr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .deg        (deg_eff),
        .taps       (tap_mask_reg),
        .init_fill  (init_fill_reg),
        .lfsr_state (lfsr_state)
    );

    // ---- output register ----
    // Holds one remainder so the next message can start while it waits.
    logic             m_valid_reg;
    logic [CRC_W-1:0] crc_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            crc_reg <= CRC_W'(lfsr_state);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_crc_value = crc_reg;

    // a pending remainder is never overwritten
    `BSC_ASSERT_IMP(a_no_overwrite, aclk, aresetn, out_load, !m_valid_reg || m_ready)
    // no message bit is taken while a remainder is being handed over
    `BSC_ASSERT_IMP(a_load_blocks_input, aclk, aresetn, out_load, !s_ready)

endmodule
